>>> src/jse_pkg.sv
package jse_pkg;

  // Width of the emitted-byte counter
  localparam int COUNT_BITS = 32;
  // Compare width: holds counter, limit and one chunk without wrap
  localparam int CMP_W = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Chunk queue between classifier and emitter
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_A_LOW  = 8'h61;

  // Control bytes with a short escape
  localparam logic [7:0] C_BS = 8'h08;
  localparam logic [7:0] C_HT = 8'h09;
  localparam logic [7:0] C_LF = 8'h0A;
  localparam logic [7:0] C_FF = 8'h0C;
  localparam logic [7:0] C_CR = 8'h0D;
  localparam logic [7:0] C_SPACE = 8'h20;
  localparam logic [7:0] C_ASCII_MAX = 8'h7F;

  // UTF-8 lead and continuation limits
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_SUR = 8'hED;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] E0_MIN    = 8'hA0;
  localparam logic [7:0] ED_MAX    = 8'h9F;
  localparam logic [7:0] F0_MIN    = 8'h90;
  localparam logic [7:0] F4_MAX    = 8'h8F;

  typedef enum logic [1:0] {
    K_QUOTE,
    K_PLAIN,
    K_SHORT,
    K_HEX
  } kind_t;

  // One output chunk; data[0] holds the escape char or the escaped byte
  typedef struct packed {
    kind_t           kind;
    logic [3:0][7:0] data;
    logic [2:0]      olen;
    logic            last;
  } chunk_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_string;
    logic       last_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       limit_error;
  } out_item_t;

  // Second char of a two-char escape, zero if none
  function automatic logic [7:0] short_esc(input logic [7:0] c);
    logic [7:0] r;
    r = 8'h00;
    case (c)
      CH_QUOTE:  r = CH_QUOTE;
      CH_BSLASH: r = CH_BSLASH;
      C_BS:      r = CH_B;
      C_FF:      r = CH_F;
      C_LF:      r = CH_N;
      C_CR:      r = CH_R;
      C_HT:      r = CH_T;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  // Sequence length from lead byte, zero for an invalid lead
  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] r;
    r = 3'd0;
    if (c >= LEAD2_LO && c <= LEAD2_HI) r = 3'd2;
    else if (c >= LEAD3_LO && c <= LEAD3_HI) r = 3'd3;
    else if (c >= LEAD4_LO && c <= LEAD4_HI) r = 3'd4;
    return r;
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic r;
    if (lead == LEAD3_LO) r = (b >= E0_MIN) && (b <= CONT_HI);
    else if (lead == LEAD3_SUR) r = (b >= CONT_LO) && (b <= ED_MAX);
    else if (lead == LEAD4_LO) r = (b >= F0_MIN) && (b <= CONT_HI);
    else if (lead == LEAD4_HI) r = (b >= CONT_LO) && (b <= F4_MAX);
    else r = (b[7:6] == 2'b10);
    return r;
  endfunction

  // Lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = CH_ZERO + {4'b0, n};
    else r = CH_A_LOW + {4'b0, n} - 8'd10;
    return r;
  endfunction

endpackage

>>> src/json_string_escaper_utf8.sv
// Channel  Direction  Ports                                 Transfer
// in       input      in_valid, in_ready, in_data           one string byte
// out      output     out_valid, out_ready, out_data        one JSON text byte
// cfg      input      cfg_valid, cfg_ready, cfg_max_output_bytes  output limit
//
// Plain bytes and whole UTF-8 sequences go in at one transaction per cycle while
// the chunk queue has room. The classifier pushes one chunk per output chunk,
// plus one for each quote, and none for an item that only extends a held sequence;
// output drains one byte per cycle while out_ready is high, so escapes (2 or 6 bytes)
// set the rate once the 4-entry chunk queue fills.
// Reset is synchronous; no clearing pass. cfg_ready is always high.
module json_string_escaper_utf8 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jse_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_max_output_bytes
);

  logic            q_push, q_full, q_pop, q_empty;
  jse_pkg::chunk_t q_chunk, q_head;

  jse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_chunk  (q_chunk)
  );

  jse_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_chunk),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  jse_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_output_bytes (cfg_max_output_bytes),
    .q_head               (q_head),
    .q_empty              (q_empty),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data             (out_data)
  );

endmodule

>>> src/jse_fifo.sv
module jse_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jse_pkg::chunk_t  din,
  output logic             full,
  input  logic             pop,
  output jse_pkg::chunk_t  dout,
  output logic             empty
);

  jse_pkg::chunk_t mem_r [jse_pkg::QDEPTH];
  logic [jse_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [jse_pkg::QPTR_W:0]   cnt_r;

  assign full  = (cnt_r == (jse_pkg::QPTR_W+1)'(jse_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rptr_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wptr_r] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push && !full) wptr_r <= wptr_r + 1'b1;
      if (pop && !empty) rptr_r <= rptr_r + 1'b1;
      if ((push && !full) && !(pop && !empty)) cnt_r <= cnt_r + 1'b1;
      else if (!(push && !full) && (pop && !empty)) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> src/jse_front.sv
module jse_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jse_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output jse_pkg::chunk_t   q_chunk
);

  typedef enum logic [1:0] {ST_IDLE, ST_OPEN, ST_SCAN, ST_CLOSE} state_t;

  // Classification of the byte at one buffer position
  typedef struct packed {
    logic           brk;
    jse_pkg::kind_t kind;
    logic [2:0]     adv;
  } cls_t;

  state_t          state_r, state_nxt;
  logic [3:0][7:0] buf_r, buf_nxt;
  logic [2:0]      n_r, n_nxt;
  logic [1:0]      pos_r, pos_nxt;
  logic            last_r, last_nxt;
  logic [2:0][7:0] pend_r, pend_nxt;
  logic [1:0]      pcnt_r, pcnt_nxt;

  cls_t       cls [4];
  cls_t       cur;
  logic [2:0] newpos;
  logic       end_scan;
  logic       scan_end;
  logic [2:0] end_pos;
  logic       done_now;
  logic [1:0] pc;
  logic [2:0] pidx;
  logic [7:0] c;

  function automatic cls_t classify(input logic [3:0][7:0] b, input logic [2:0] n,
                                    input logic [1:0] p, input logic lst);
    cls_t       r;
    logic [7:0] ch;
    logic [2:0] slen, avail, lim, idx;
    logic       bad;
    ch    = b[p];
    r.brk = 1'b0;
    r.kind = jse_pkg::K_PLAIN;
    r.adv = 3'd1;
    bad   = 1'b0;
    slen  = jse_pkg::seq_len(ch);
    avail = n - {1'b0, p};
    lim   = (avail < slen) ? avail : slen;
    if (jse_pkg::short_esc(ch) != 8'h00) begin
      r.kind = jse_pkg::K_SHORT;
    end else if (ch < jse_pkg::C_SPACE) begin
      r.kind = jse_pkg::K_HEX;
    end else if (ch > jse_pkg::C_ASCII_MAX) begin
      if (slen == 3'd0) begin
        r.kind = jse_pkg::K_HEX;
      end else begin
        // check every available follow byte of the sequence
        for (int k = 1; k < 4; k++) begin
          idx = 3'({1'b0, p}) + 3'(k);
          if (3'(k) < lim && idx < 3'd4) begin
            if (k == 1) begin
              if (!jse_pkg::second_ok(ch, b[idx[1:0]])) bad = 1'b1;
            end else begin
              if (b[idx[1:0]][7:6] != 2'b10) bad = 1'b1;
            end
          end
        end
        if (bad) r.kind = jse_pkg::K_HEX;
        else if (avail < slen) begin
          if (lst) r.kind = jse_pkg::K_HEX;
          else r.brk = 1'b1;
        end else r.adv = slen;
      end
    end
    return r;
  endfunction

  // Classify all positions in parallel
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      cls[p] = classify(buf_r, n_r, 2'(p), last_r);
    end
  end

  assign cur      = cls[pos_r];
  assign newpos   = {1'b0, pos_r} + cur.adv;
  assign end_scan = (newpos >= n_r) || cls[newpos[1:0]].brk;
  assign c        = buf_r[pos_r];

  // Sequencer: one chunk per cycle into the queue while the queue is not full
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    buf_nxt   = buf_r;
    n_nxt     = n_r;
    last_nxt  = last_r;
    q_push    = 1'b0;
    scan_end  = 1'b0;
    end_pos   = {1'b0, pos_r};
    done_now  = 1'b0;
    pidx      = '0;
    q_chunk.kind = jse_pkg::K_QUOTE;
    q_chunk.data = '0;
    q_chunk.data[0] = jse_pkg::CH_QUOTE;
    q_chunk.olen = 3'd1;
    q_chunk.last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_OPEN: begin
        q_push = !q_full;
        q_chunk.last = cls[0].brk && !last_r;
        if (q_push) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cur.brk) begin
          scan_end = 1'b1;
          done_now = 1'b1;
        end else begin
          q_push = !q_full;
          q_chunk.kind = cur.kind;
          for (int i = 0; i < 4; i++) begin
            q_chunk.data[i] = buf_r[2'(pos_r + 2'(i))];
          end
          unique case (cur.kind)
            jse_pkg::K_SHORT: begin
              q_chunk.data[0] = jse_pkg::short_esc(c);
              q_chunk.olen = 3'd2;
            end
            jse_pkg::K_HEX:   q_chunk.olen = 3'd6;
            jse_pkg::K_PLAIN: q_chunk.olen = cur.adv;
            default:          q_chunk.olen = 3'd1;
          endcase
          q_chunk.last = end_scan && !last_r;
          if (q_push) begin
            if (end_scan) begin
              scan_end = 1'b1;
              end_pos  = newpos;
              if (last_r) state_nxt = ST_CLOSE;
              else done_now = 1'b1;
            end else begin
              pos_nxt = newpos[1:0];
            end
          end
        end
      end
      ST_CLOSE: begin
        q_push = !q_full;
        q_chunk.last = 1'b1;
        if (q_push) done_now = 1'b1;
      end
      default: begin
      end
    endcase
    if (done_now) state_nxt = ST_IDLE;

    // Leftover valid prefix becomes the pending bytes
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    if (scan_end) begin
      for (int i = 0; i < 3; i++) begin
        pidx = end_pos + 3'(i);
        pend_nxt[i] = buf_r[pidx[1:0]];
      end
      pcnt_nxt = 2'(n_r - end_pos);
    end

    // Load a new transaction: pending bytes then the new byte
    in_ready = (state_r == ST_IDLE) || done_now;
    pc = in_data.first_of_string ? 2'd0 : pcnt_nxt;
    if (in_valid && in_ready) begin
      buf_nxt[0] = (pc > 2'd0) ? pend_nxt[0] : in_data.data_byte;
      buf_nxt[1] = (pc > 2'd1) ? pend_nxt[1] : in_data.data_byte;
      buf_nxt[2] = (pc > 2'd2) ? pend_nxt[2] : in_data.data_byte;
      buf_nxt[3] = in_data.data_byte;
      n_nxt      = {1'b0, pc} + 3'd1;
      pos_nxt    = 2'd0;
      last_nxt   = in_data.last_of_string;
      state_nxt  = in_data.first_of_string ? ST_OPEN : ST_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      pcnt_r  <= pcnt_nxt;
    end
    buf_r  <= buf_nxt;
    n_r    <= n_nxt;
    pos_r  <= pos_nxt;
    last_r <= last_nxt;
    pend_r <= pend_nxt;
  end

endmodule

>>> src/jse_back.sv
module jse_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_max_output_bytes,
  input  jse_pkg::chunk_t    q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output jse_pkg::out_item_t out_data
);

  logic [31:0]                     max_r;
  logic [jse_pkg::COUNT_BITS-1:0]  emitted_r, emitted_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [2:0]                      idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  jse_pkg::out_item_t              out_data_r, out_data_nxt;

  logic                     load;
  logic [jse_pkg::CMP_W-1:0] sum;
  logic                     fits;
  logic                     ovf_eff;
  logic [7:0]               byte_raw;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign load  = !q_empty && (!out_valid_r || out_ready);
  assign q_pop = load && (idx_r == q_head.olen - 3'd1);

  // Whole-chunk fit check against the limit and the counter range
  assign sum  = jse_pkg::CMP_W'(emitted_r) + jse_pkg::CMP_W'(q_head.olen);
  assign fits = (sum <= jse_pkg::CMP_W'(max_r)) &&
                (sum <= jse_pkg::CMP_W'(jse_pkg::CNT_MAX));
  assign ovf_eff = (idx_r == 3'd0) ? (ovf_r || !fits) : ovf_r;

  // Byte of the current chunk at idx_r
  always_comb begin
    byte_raw = jse_pkg::CH_QUOTE;
    unique case (q_head.kind)
      jse_pkg::K_QUOTE: byte_raw = jse_pkg::CH_QUOTE;
      jse_pkg::K_PLAIN: byte_raw = q_head.data[idx_r[1:0]];
      jse_pkg::K_SHORT: byte_raw = (idx_r == 3'd0) ? jse_pkg::CH_BSLASH : q_head.data[0];
      jse_pkg::K_HEX: begin
        unique case (idx_r) inside
          3'd0:       byte_raw = jse_pkg::CH_BSLASH;
          3'd1:       byte_raw = jse_pkg::CH_U;
          3'd2, 3'd3: byte_raw = jse_pkg::CH_ZERO;
          3'd4:       byte_raw = jse_pkg::hex_char(q_head.data[0][7:4]);
          default:    byte_raw = jse_pkg::hex_char(q_head.data[0][3:0]);
        endcase
      end
      default: byte_raw = jse_pkg::CH_QUOTE;
    endcase
  end

  // Output register and limit bookkeeping
  always_comb begin
    emitted_nxt   = emitted_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_byte    = ovf_eff ? 8'h00 : byte_raw;
      out_data_nxt.limit_error = ovf_eff;
      out_data_nxt.last_in_run = q_head.last && q_pop;
      idx_nxt = q_pop ? 3'd0 : idx_r + 3'd1;
      if (idx_r == 3'd0) begin
        ovf_nxt = ovf_eff;
        if (!ovf_eff) emitted_nxt = sum[jse_pkg::COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= 32'hFFFF_FFFF;
      emitted_r   <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) max_r <= cfg_max_output_bytes;
      emitted_r   <= emitted_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

>>> src/jse_checker.sv
module jse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input jse_pkg::out_item_t out_data
);

  logic seen_err_r;

  // Remember a suppressed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_err_r <= 1'b0;
    end else if (out_valid && out_ready && out_data.limit_error) begin
      seen_err_r <= 1'b1;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out transaction changed while stalled");

  // Limit error is sticky
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_err_r |-> out_data.limit_error)
    else $error("limit_error dropped after being set");

  // Real output bytes are never zero; suppressed ones always are
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.out_byte == 8'h00) == out_data.limit_error))
    else $error("out_byte and limit_error disagree");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind json_string_escaper_utf8 jse_checker u_jse_checker (.*);

>>> dv/json_string_escaper_utf8_tb.sv
`timescale 1ns / 1ps

module json_string_escaper_utf8_tb;

  // Character and UTF-8 boundary codes
  localparam logic [7:0] QUOTE     = 8'h22;
  localparam logic [7:0] BSLASH    = 8'h5C;
  localparam logic [7:0] LETTER_U  = 8'h75;
  localparam logic [7:0] DIG0      = 8'h30;
  localparam logic [7:0] ALPHA_OFS = 8'h57;  // 'a' - 10
  localparam logic [7:0] SPACE     = 8'h20;
  localparam logic [7:0] ASCII_TOP = 8'h7F;
  localparam logic [7:0] L2_MIN    = 8'hC2;
  localparam logic [7:0] L2_MAX    = 8'hDF;
  localparam logic [7:0] L3_MIN    = 8'hE0;
  localparam logic [7:0] L3_SURR   = 8'hED;
  localparam logic [7:0] L3_MAX    = 8'hEF;
  localparam logic [7:0] L4_MIN    = 8'hF0;
  localparam logic [7:0] L4_MAX    = 8'hF4;
  localparam logic [7:0] CONT_MIN  = 8'h80;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] E0_FLOOR  = 8'hA0;
  localparam logic [7:0] ED_CEIL   = 8'h9F;
  localparam logic [7:0] F0_FLOOR  = 8'h90;
  localparam logic [7:0] F4_CEIL   = 8'h8F;
  localparam logic [63:0] CNT_TOP  = 64'(jse_pkg::CNT_MAX);

  localparam int HOLD_CYC  = 300;
  localparam int SETTLE    = 16;
  localparam int WD_LIMIT  = 4000;
  localparam int MAX_PRINT = 100;
  localparam int N_DIR     = 26;

  typedef struct {
    jse_pkg::in_item_t item;
    bit                typed;
    string             txt;
  } stim_t;

  typedef struct {
    logic [7:0] b;
    bit         f;
    bit         l;
    bit         typed;
    string      txt;
  } dir_row_t;

  // Directed rows; txt is the exact output where it is obvious
  dir_row_t dir_tab [N_DIR] = '{
    '{8'h41, 1, 1, 1, "\"A\""},
    '{8'h22, 1, 1, 1, "\"\\\"\""},
    '{8'h5C, 1, 1, 1, "\"\\\\\""},
    '{8'h08, 1, 0, 1, "\"\\b"},
    '{8'h0C, 0, 0, 1, "\\f"},
    '{8'h0A, 0, 0, 1, "\\n"},
    '{8'h0D, 0, 0, 1, "\\r"},
    '{8'h09, 0, 1, 1, "\\t\""},
    '{8'h00, 1, 0, 1, "\"\\u0000"},
    '{8'h1F, 0, 0, 1, "\\u001f"},
    '{8'h7F, 0, 0, 0, ""},
    '{8'hFF, 0, 0, 1, "\\u00ff"},
    '{8'hC1, 0, 0, 1, "\\u00c1"},
    '{8'hC2, 0, 0, 0, ""},   // held, nothing out
    '{8'h80, 0, 0, 0, ""},
    '{8'hE0, 0, 0, 0, ""},
    '{8'h9F, 0, 0, 0, ""},   // overlong after E0
    '{8'hED, 0, 0, 0, ""},
    '{8'hA0, 0, 0, 0, ""},   // surrogate after ED
    '{8'hF4, 0, 0, 0, ""},
    '{8'h8F, 0, 0, 0, ""},
    '{8'hBF, 0, 0, 0, ""},
    '{8'hBF, 0, 0, 0, ""},   // highest code point
    '{8'hF0, 0, 0, 0, ""},
    '{8'h90, 0, 1, 0, ""},   // cut short by end of string
    '{8'hE1, 1, 0, 0, ""}    // left pending for the next string
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  jse_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  jse_pkg::out_item_t  out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [31:0]         cfg_max_output_bytes = '0;

  // Escaper state mirror
  logic [7:0]  pend_b [3];
  int          pend_n = 0;
  logic [63:0] sent_cnt = '0;
  bit          over = 1'b0;
  logic [31:0] lim_reg = 32'hFFFF_FFFF;

  jse_pkg::out_item_t run_q[$];   // bytes caused by the current input
  jse_pkg::out_item_t exp_q[$];   // bytes still owed by the block
  stim_t              stim_q[$];

  int    snd_idle = 0;
  int    rcv_idle = 0;
  int    hold_seq = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    quiet = 0;
  int    err_cnt = 0;
  int    n_queued = 0;
  int    n_taken = 0;
  int    n_rcvd = 0;
  stim_t in_cur;
  bit    nxt_v;

  json_string_escaper_utf8 dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data              (in_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data             (out_data),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_output_bytes (cfg_max_output_bytes)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? DIG0 + 8'(v) : ALPHA_OFS + 8'(v);
  endfunction

  function automatic logic [7:0] esc_letter(input logic [7:0] c);
    case (c)
      QUOTE:  return QUOTE;
      BSLASH: return BSLASH;
      8'h08:  return 8'h62;  // b
      8'h0C:  return 8'h66;  // f
      8'h0A:  return 8'h6E;  // n
      8'h0D:  return 8'h72;  // r
      8'h09:  return 8'h74;  // t
      default: return 8'h00;
    endcase
  endfunction

  function automatic int utf8_len(input logic [7:0] c);
    if (c >= L2_MIN && c <= L2_MAX) return 2;
    if (c >= L3_MIN && c <= L3_MAX) return 3;
    if (c >= L4_MIN && c <= L4_MAX) return 4;
    return 0;
  endfunction

  // Second byte rules exclude overlongs, surrogates and code points past 10FFFF
  function automatic bit second_fits(input logic [7:0] lead, input logic [7:0] b);
    case (lead)
      L3_MIN:  return b >= E0_FLOOR && b <= CONT_MAX;
      L3_SURR: return b >= CONT_MIN && b <= ED_CEIL;
      L4_MIN:  return b >= F0_FLOOR && b <= CONT_MAX;
      L4_MAX:  return b >= CONT_MIN && b <= F4_CEIL;
      default: return b[7:6] == 2'b10;
    endcase
  endfunction

  // A chunk goes out whole or, past the limit, as zeros with the sticky error
  function automatic void emit_chunk(input logic [5:0][7:0] ch, input int len);
    jse_pkg::out_item_t r;
    if (!over) begin
      if (sent_cnt <= {32'd0, lim_reg} && 64'(len) <= {32'd0, lim_reg} - sent_cnt &&
          sent_cnt <= CNT_TOP && 64'(len) <= CNT_TOP - sent_cnt)
        sent_cnt += 64'(len);
      else
        over = 1'b1;
    end
    for (int k = 0; k < len; k++) begin
      r.out_byte    = over ? 8'h00 : ch[k];
      r.last_in_run = 1'b0;
      r.limit_error = over;
      run_q.push_back(r);
    end
  endfunction

  function automatic void emit_hex(input logic [7:0] c);
    emit_chunk({hex_digit(c[3:0]), hex_digit(c[7:4]), DIG0, DIG0, LETTER_U, BSLASH}, 6);
  endfunction

  // Quoted output for one input byte, pending UTF-8 prefix included
  function automatic void predict_run(input jse_pkg::in_item_t it);
    logic [7:0]      seq [4];
    logic [5:0][7:0] ch;
    logic [7:0]      c;
    logic [7:0]      s;
    int              n;
    int              pos;
    int              len;
    int              avail;
    int              span;
    bit              bad;
    run_q.delete();
    n = 0;
    pos = 0;
    if (it.first_of_string) begin
      pend_n = 0;
      emit_chunk(48'(QUOTE), 1);
    end
    for (int k = 0; k < pend_n; k++) begin
      seq[n] = pend_b[k];
      n++;
    end
    seq[n] = it.data_byte;
    n++;
    while (pos < n) begin
      c = seq[pos];
      s = esc_letter(c);
      len = utf8_len(c);
      if (s != 8'h00) begin
        emit_chunk({32'd0, s, BSLASH}, 2);
        pos++;
      end else if (c < SPACE || (c > ASCII_TOP && len == 0)) begin
        emit_hex(c);
        pos++;
      end else if (c <= ASCII_TOP) begin
        emit_chunk(48'(c), 1);
        pos++;
      end else begin
        avail = n - pos;
        span = (avail < len) ? avail : len;
        bad = 1'b0;
        for (int k = 1; k < span; k++) begin
          if (k == 1 ? !second_fits(c, seq[pos + k]) : seq[pos + k][7:6] != 2'b10)
            bad = 1'b1;
        end
        if (bad || (avail < len && it.last_of_string)) begin
          emit_hex(c);
          pos++;
        end else if (avail < len) begin
          break;
        end else begin
          ch = '0;
          for (int k = 0; k < len; k++) ch[k] = seq[pos + k];
          emit_chunk(ch, len);
          pos += len;
        end
      end
    end
    // Valid prefix waits for more bytes
    pend_n = 0;
    while (pos < n && pend_n < 3) begin
      pend_b[pend_n] = seq[pos];
      pend_n++;
      pos++;
    end
    if (it.last_of_string) emit_chunk(48'(QUOTE), 1);
    if (run_q.size() > 0) run_q[run_q.size() - 1].last_in_run = 1'b1;
  endfunction

  function automatic logic [3:0][7:0] make_utf8(input int len);
    logic [3:0][7:0] u;
    for (int k = 0; k < 4; k++) u[k] = 8'($urandom_range(CONT_MIN, CONT_MAX));
    case (len)
      2: u[0] = 8'($urandom_range(L2_MIN, L2_MAX));
      3: begin
        u[0] = 8'($urandom_range(L3_MIN, L3_MAX));
        if (u[0] == L3_MIN) u[1] = 8'($urandom_range(E0_FLOOR, CONT_MAX));
        if (u[0] == L3_SURR) u[1] = 8'($urandom_range(CONT_MIN, ED_CEIL));
      end
      default: begin
        u[0] = 8'($urandom_range(L4_MIN, L4_MAX));
        if (u[0] == L4_MIN) u[1] = 8'($urandom_range(F0_FLOOR, CONT_MAX));
        if (u[0] == L4_MAX) u[1] = 8'($urandom_range(CONT_MIN, F4_CEIL));
      end
    endcase
    return u;
  endfunction

  // One random string: mostly text and whole sequences, some broken ones and noise
  task automatic queue_string();
    logic [7:0]      bytes_q[$];
    logic [3:0][7:0] u;
    int              pick;
    int              len;
    int              keep;
    bit              opn;
    bit              cls;
    stim_t           s;
    opn = ($urandom_range(9) != 0);
    cls = ($urandom_range(9) != 0);
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        bytes_q.push_back(8'($urandom_range(SPACE, ASCII_TOP - 1)));
      end else if (pick < 50) begin
        bytes_q.push_back(8'($urandom_range(SPACE - 1)));
      end else if (pick < 55) begin
        case ($urandom_range(2))
          0: bytes_q.push_back(QUOTE);
          1: bytes_q.push_back(BSLASH);
          default: bytes_q.push_back(ASCII_TOP);
        endcase
      end else if (pick < 94) begin
        len = $urandom_range(2, 4);
        u = make_utf8(len);
        keep = (pick < 88) ? len : $urandom_range(1, len - 1);
        for (int k = 0; k < keep; k++) bytes_q.push_back(u[k]);
      end else begin
        bytes_q.push_back(8'($urandom_range(255)));
      end
    end
    foreach (bytes_q[j]) begin
      s.item.data_byte       = bytes_q[j];
      s.item.first_of_string = opn && j == 0;
      s.item.last_of_string  = cls && j == bytes_q.size() - 1;
      s.typed = 1'b0;
      s.txt = "";
      stim_q.push_back(s);
      n_queued++;
    end
  endtask

  task automatic run_random(input int n_items);
    int goal;
    goal = n_queued + n_items;
    while (n_queued < goal) queue_string();
  endtask

  task automatic report_err(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINT) $display("mismatch: %s", msg);
  endtask

  // Accepted input transaction: owe its bytes
  task automatic take_item(input stim_t s);
    jse_pkg::out_item_t r;
    predict_run(s.item);
    if (s.typed) begin
      run_q.delete();
      for (int i = 0; i < s.txt.len(); i++) begin
        r.out_byte    = s.txt[i];
        r.last_in_run = (i == s.txt.len() - 1);
        r.limit_error = 1'b0;
        run_q.push_back(r);
      end
    end
    foreach (run_q[i]) exp_q.push_back(run_q[i]);
  endtask

  task automatic check_result(input jse_pkg::out_item_t got);
    jse_pkg::out_item_t want;
    n_rcvd++;
    if (exp_q.size() == 0) begin
      report_err($sformatf("byte %0d: %02h with nothing owed", n_rcvd, got.out_byte));
    end else begin
      want = exp_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_err($sformatf("byte %0d: out_byte %02h, want %02h",
                             n_rcvd, got.out_byte, want.out_byte));
      if (got.last_in_run !== want.last_in_run)
        report_err($sformatf("byte %0d: last_in_run %b, want %b",
                             n_rcvd, got.last_in_run, want.last_in_run));
      if (got.limit_error !== want.limit_error)
        report_err($sformatf("byte %0d: limit_error %b, want %b",
                             n_rcvd, got.limit_error, want.limit_error));
    end
  endtask

  // Sender: one valid update per edge, payload held until the transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_v = in_valid;
      if (in_valid && in_ready) begin
        take_item(in_cur);
        n_taken++;
        nxt_v = 1'b0;
      end
      if (!nxt_v && stim_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
        in_cur = stim_q.pop_front();
        in_data <= in_cur.item;
        nxt_v = 1'b1;
      end
      in_valid <= nxt_v;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WD_LIMIT) begin
        $display("[json_string_escaper_utf8] ERROR");
        $finish;
      end
    end
  end

  task automatic set_limit(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_max_output_bytes <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lim_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // Everything sent and answered, then let a held-only item settle
  task automatic wait_drained();
    while (n_taken != n_queued || exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    stim_t s;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle = 24;
    rcv_idle = 49;
    set_limit(32'hFFFF_FFFF);
    for (int i = 0; i < N_DIR; i++) begin
      s.item.data_byte       = dir_tab[i].b;
      s.item.first_of_string = dir_tab[i].f;
      s.item.last_of_string  = dir_tab[i].l;
      s.typed = dir_tab[i].typed;
      s.txt   = dir_tab[i].txt;
      stim_q.push_back(s);
      n_queued++;
    end
    wait_drained();
    run_random(15);
    wait_drained();
    run_random(15);
    wait_drained();

    snd_idle = 49;
    rcv_idle = 24;
    set_limit(32'($urandom_range(32'h1000_0000, 32'hFFFF_FFFE)));
    run_random(20);
    wait_drained();

    // No idling; receiver holds off so the block backs up into its input
    snd_idle = 0;
    rcv_idle = 0;
    run_random(20);
    hold_seq++;
    wait_drained();

    // Limit lands 10 to 80 bytes ahead, then drops to zero
    set_limit(sent_cnt[31:0] + 32'($urandom_range(10, 80)));
    run_random(30);
    wait_drained();
    set_limit(32'h0000_0000);
    run_random(8);
    wait_drained();

    if (exp_q.size() != 0) report_err($sformatf("%0d bytes never arrived", exp_q.size()));
    if (err_cnt == 0) begin
      $display("[json_string_escaper_utf8] OK");
    end else begin
      $display("[json_string_escaper_utf8] ERROR");
    end
    $finish;
  end

endmodule
